// ===== rtl/phlt_pkg.sv =====
package phlt_pkg;

  localparam logic [2:0] EV_PONG      = 3'd0;
  localparam logic [2:0] EV_FWD_KNOWN = 3'd1;
  localparam logic [2:0] EV_FWD_NEW   = 3'd2;
  localparam logic [2:0] EV_FWD_FULL  = 3'd3;
  localparam logic [2:0] EV_PING      = 3'd4;
  localparam logic [2:0] EV_OFFLINE   = 3'd5;
  localparam logic [2:0] EV_DONE      = 3'd6;

  localparam logic [1:0] TC_UNICAST   = 2'd0;
  localparam logic [1:0] TC_MULTICAST = 2'd1;
  localparam logic [1:0] TC_BROADCAST = 2'd2;

  localparam logic [7:0]  MISSED_MAX    = 8'hFF;
  localparam logic [7:0]  MAX_MISSED_RST = 8'd3;
  localparam logic [3:0]  MCAST_PREFIX  = 4'hE;
  localparam logic [31:0] BCAST_ADDR    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        action;
    logic        payload_is_pong;
    logic [31:0] sender_ip;
    logic [15:0] sender_port;
    logic [31:0] dest_ip;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [1:0]  traffic_class;
    logic        last;
  } out_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [15:0] port;
    logic [7:0]  missed;
  } slot_t;

  // Broadcast from the top level to every cell
  typedef struct packed {
    logic        shift;
    logic        commit;
    logic        pong;
    logic        hit_any;
    logic [31:0] ip;
    logic [15:0] port;
  } cell_cmd_t;

endpackage

// ===== rtl/phlt_cell.sv =====
module phlt_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  phlt_pkg::cell_cmd_t cmd_i,
  input  phlt_pkg::slot_t    nxt_i,
  input  logic               free_seen_i,
  output logic               free_seen_o,
  input  logic               hit_seen_i,
  output logic               hit_seen_o,
  output phlt_pkg::slot_t    slot_o
);
  import phlt_pkg::*;

  logic        valid_q;
  logic [31:0] ip_q;
  logic [15:0] port_q;
  logic [7:0]  missed_q;
  logic        match;
  logic        claim;

  assign match       = valid_q && (ip_q == cmd_i.ip) && (port_q == cmd_i.port);
  // lowest free slot takes a new peer
  assign claim       = !valid_q && !free_seen_i;
  assign free_seen_o = free_seen_i | !valid_q;
  assign hit_seen_o  = hit_seen_i | match;

  assign slot_o = '{valid: valid_q, ip: ip_q, port: port_q, missed: missed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      priority if (cmd_i.shift) begin
        valid_q <= nxt_i.valid;
      end else if (cmd_i.commit && claim && !cmd_i.pong && !cmd_i.hit_any) begin
        valid_q <= 1'b1;
      end else begin
        valid_q <= valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.shift) begin
      ip_q     <= nxt_i.ip;
      port_q   <= nxt_i.port;
      missed_q <= nxt_i.missed;
    end else if (cmd_i.commit && match) begin
      missed_q <= 8'd0;
    end else if (cmd_i.commit && claim && !cmd_i.pong && !cmd_i.hit_any) begin
      ip_q     <= cmd_i.ip;
      port_q   <= cmd_i.port;
      missed_q <= 8'd0;
    end else begin
      missed_q <= missed_q;
    end
  end

endmodule

// ===== rtl/peer_heartbeat_liveness_table_top.sv =====
// Heartbeat keepalive table for up to TABLE_DEPTH IPv4 peers, held in a row of
// cells, one peer per cell. A datagram is registered when taken, then matched
// against every cell at once, and gives one result. A heartbeat tick rotates
// the whole table one cell a cycle through the head cell, where each valid peer
// is pinged or dropped, until every cell has passed the head once; then the
// done marker follows. A stalled output holds the rotation at a valid peer
// until its result is taken. The user must write the threshold register
// through cfg_we_i / cfg_wdata_i only while the block is idle; the block
// itself does not enforce it.
module peer_heartbeat_liveness_table_top #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  phlt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output phlt_pkg::out_t  out_data_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i
);
  import phlt_pkg::*;

  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_DGRAM, S_SWEEP} state_e;

  state_e          state_q;
  in_t             item_q;
  logic [CntW-1:0] cnt_q;
  logic [7:0]      max_q;
  logic            out_valid_q;
  out_t            out_q;

  slot_t           slots [TABLE_DEPTH];
  logic [TABLE_DEPTH:0] free_seen;
  logic [TABLE_DEPTH:0] hit_seen;
  cell_cmd_t       cmd;
  slot_t           head;
  slot_t           wrap;
  logic [7:0]      inc;
  logic            offline;
  logic            out_free;
  logic            out_load;
  logic            sweep_run;
  logic [1:0]      cls;
  out_t            dg_res;
  out_t            sw_res;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign head      = slots[0];
  assign inc       = (head.missed == MISSED_MAX) ? MISSED_MAX : head.missed + 8'd1;
  assign offline   = (inc >= max_q);
  assign sweep_run = (state_q == S_SWEEP) && (cnt_q != CntW'(TABLE_DEPTH));

  // a new result enters the output register this cycle
  assign out_load = ((state_q == S_DGRAM) && out_free) ||
                    (cmd.shift && head.valid) ||
                    ((state_q == S_SWEEP) && !sweep_run && out_free);

  // head entry re-enters at the tail, aged or dropped
  always_comb begin
    wrap = head;
    if (head.valid) begin
      wrap.missed = inc;
      wrap.valid  = !offline;
    end
  end

  always_comb begin
    cmd.shift   = sweep_run && (!head.valid || out_free);
    cmd.commit  = (state_q == S_DGRAM) && out_free;
    cmd.pong    = item_q.payload_is_pong;
    cmd.hit_any = hit_seen[TABLE_DEPTH];
    cmd.ip      = item_q.sender_ip;
    cmd.port    = item_q.sender_port;
  end

  assign free_seen[0] = 1'b0;
  assign hit_seen[0]  = 1'b0;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    slot_t nxt;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign nxt = wrap;
    end else begin : g_mid
      assign nxt = slots[k+1];
    end
    phlt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .nxt_i       (nxt),
      .free_seen_i (free_seen[k]),
      .free_seen_o (free_seen[k+1]),
      .hit_seen_i  (hit_seen[k]),
      .hit_seen_o  (hit_seen[k+1]),
      .slot_o      (slots[k])
    );
  end

  always_comb begin
    priority if (item_q.dest_ip[31:28] == MCAST_PREFIX) begin
      cls = TC_MULTICAST;
    end else if (item_q.dest_ip == BCAST_ADDR) begin
      cls = TC_BROADCAST;
    end else begin
      cls = TC_UNICAST;
    end
  end

  always_comb begin
    dg_res.peer_ip       = item_q.sender_ip;
    dg_res.peer_port     = item_q.sender_port;
    dg_res.last          = 1'b1;
    dg_res.traffic_class = cls;
    priority if (item_q.payload_is_pong) begin
      dg_res.event_res     = EV_PONG;
      dg_res.traffic_class = TC_UNICAST;
    end else if (hit_seen[TABLE_DEPTH]) begin
      dg_res.event_res = EV_FWD_KNOWN;
    end else if (free_seen[TABLE_DEPTH]) begin
      dg_res.event_res = EV_FWD_NEW;
    end else begin
      dg_res.event_res = EV_FWD_FULL;
    end
  end

  always_comb begin
    sw_res.event_res     = offline ? EV_OFFLINE : EV_PING;
    sw_res.peer_ip       = head.ip;
    sw_res.peer_port     = head.port;
    sw_res.traffic_class = TC_UNICAST;
    sw_res.last          = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      max_q       <= MAX_MISSED_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            cnt_q   <= '0;
            state_q <= in_data_i.action ? S_SWEEP : S_DGRAM;
          end
        end
        S_DGRAM: begin
          if (out_free) begin
            out_q   <= dg_res;
            state_q <= S_IDLE;
          end
        end
        S_SWEEP: begin
          if (sweep_run) begin
            if (cmd.shift) begin
              cnt_q <= cnt_q + CntW'(1);
              if (head.valid) begin
                out_q <= sw_res;
              end
            end
          end else if (out_free) begin
            out_q   <= '{event_res: EV_DONE, peer_ip: 32'd0, peer_port: 16'd0,
                         traffic_class: TC_UNICAST, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/phlt_checker.sv =====
module phlt_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input phlt_pkg::out_t out_data_o
);
  import phlt_pkg::*;

  // an accepted transaction keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a transaction was taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_done_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == EV_DONE) |->
      (out_data_o.peer_ip == 32'd0) && (out_data_o.peer_port == 16'd0) &&
      out_data_o.last)
    else $error("done marker carries peer fields or lacks last");

  a_last_events: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last ==
      ((out_data_o.event_res != EV_PING) && (out_data_o.event_res != EV_OFFLINE))))
    else $error("last flag disagrees with event");

endmodule

bind peer_heartbeat_liveness_table_top phlt_checker u_phlt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== tb/sv/peer_heartbeat_liveness_table_top_test.sv =====
`timescale 1ns / 1ps

module peer_heartbeat_liveness_table_top_test;
  import phlt_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int POOL_SIZE    = 24;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 6;
  localparam logic ACT_DATAGRAM = 1'b0;
  localparam logic ACT_TICK     = 1'b1;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  in_t        in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  out_t       out_data_o;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  // Mirror of the peer table and the offline threshold
  logic        tbl_valid  [TABLE_DEPTH];
  logic [31:0] tbl_ip     [TABLE_DEPTH];
  logic [15:0] tbl_port   [TABLE_DEPTH];
  logic [7:0]  tbl_missed [TABLE_DEPTH];
  logic [7:0]  offline_limit;

  out_t        pending_events[$];
  logic [31:0] pool_ip   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  int          error_count;
  bit          idle_en;
  int          rx_hold_cycles;

  peer_heartbeat_liveness_table_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void queue_event(input logic [2:0] ev, input logic [31:0] ip,
                                      input logic [15:0] port, input logic [1:0] cls,
                                      input logic lst);
    out_t r;
    r.event_res     = ev;
    r.peer_ip       = ip;
    r.peer_port     = port;
    r.traffic_class = cls;
    r.last          = lst;
    pending_events.push_back(r);
  endfunction

  // Apply one accepted transaction to the mirror table and queue its events
  function automatic void track_peers(input in_t it);
    int hit;
    int free_slot;
    logic [1:0] cls;
    hit = -1;
    free_slot = -1;
    if (it.action == ACT_TICK) begin
      for (int s = 0; s < TABLE_DEPTH; s++) begin
        if (tbl_valid[s]) begin
          if (tbl_missed[s] != MISSED_MAX) tbl_missed[s] = tbl_missed[s] + 8'd1;
          if (tbl_missed[s] >= offline_limit) begin
            queue_event(EV_OFFLINE, tbl_ip[s], tbl_port[s], TC_UNICAST, 1'b0);
            tbl_valid[s] = 1'b0;
          end else begin
            queue_event(EV_PING, tbl_ip[s], tbl_port[s], TC_UNICAST, 1'b0);
          end
        end
      end
      queue_event(EV_DONE, '0, '0, TC_UNICAST, 1'b1);
      return;
    end
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (tbl_valid[s] && hit < 0 && tbl_ip[s] == it.sender_ip &&
          tbl_port[s] == it.sender_port) hit = s;
      if (!tbl_valid[s] && free_slot < 0) free_slot = s;
    end
    if (hit >= 0) tbl_missed[hit] = '0;
    if (it.payload_is_pong) begin
      queue_event(EV_PONG, it.sender_ip, it.sender_port, TC_UNICAST, 1'b1);
      return;
    end
    if (it.dest_ip[31:28] == MCAST_PREFIX) cls = TC_MULTICAST;
    else if (it.dest_ip == BCAST_ADDR) cls = TC_BROADCAST;
    else cls = TC_UNICAST;
    if (hit >= 0) begin
      queue_event(EV_FWD_KNOWN, it.sender_ip, it.sender_port, cls, 1'b1);
    end else if (free_slot >= 0) begin
      tbl_valid[free_slot]  = 1'b1;
      tbl_ip[free_slot]     = it.sender_ip;
      tbl_port[free_slot]   = it.sender_port;
      tbl_missed[free_slot] = '0;
      queue_event(EV_FWD_NEW, it.sender_ip, it.sender_port, cls, 1'b1);
    end else begin
      queue_event(EV_FWD_FULL, it.sender_ip, it.sender_port, cls, 1'b1);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        $error("unexpected result: event_res %0d peer_ip %0h", out_data_o.event_res,
               out_data_o.peer_ip);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_res", 32'(want.event_res), 32'(out_data_o.event_res));
        check_field("peer_ip", want.peer_ip, out_data_o.peer_ip);
        check_field("peer_port", 32'(want.peer_port), 32'(out_data_o.peer_port));
        check_field("traffic_class", 32'(want.traffic_class),
                    32'(out_data_o.traffic_class));
        check_field("last", 32'(want.last), 32'(out_data_o.last));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold on request
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles != 0) begin
        stall_left = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (stall_left == 0 && run_left == 0 && idle_en) begin
        if ($urandom_range(0, 1) == 1) stall_left = $urandom_range(1, 9);
        else run_left = $urandom_range(1, 24);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        if (run_left != 0) run_left--;
      end
    end
  end

  task automatic send_item(input in_t it);
    if (idle_en && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_peers(it);
  endtask

  task automatic send_datagram(input logic [31:0] ip, input logic [15:0] port,
                               input logic [31:0] dest, input logic pong);
    in_t it;
    it.action          = ACT_DATAGRAM;
    it.payload_is_pong = pong;
    it.sender_ip       = ip;
    it.sender_port     = port;
    it.dest_ip         = dest;
    send_item(it);
  endtask

  // The address fields of a tick are don't-care: fill them with noise
  task automatic send_tick();
    in_t it;
    it.action          = ACT_TICK;
    it.payload_is_pong = 1'($urandom);
    it.sender_ip       = $urandom;
    it.sender_port     = 16'($urandom);
    it.dest_ip         = $urandom;
    send_item(it);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    offline_limit = value;
  endtask

  function automatic in_t random_item();
    in_t it;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, POOL_SIZE - 1);
    it.action          = ACT_DATAGRAM;
    it.payload_is_pong = 1'b0;
    it.sender_ip       = pool_ip[pick];
    it.sender_port     = pool_port[pick];
    case ($urandom_range(0, 3))
      0: it.dest_ip = {MCAST_PREFIX, 28'($urandom)};
      1: it.dest_ip = BCAST_ADDR;
      default: it.dest_ip = $urandom;
    endcase
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      it.action          = ACT_TICK;
      it.payload_is_pong = 1'($urandom);
    end else if (sel < 35) begin
      it.payload_is_pong = 1'b1;
    end else if (sel < 45) begin
      // stranger outside the pool
      it.sender_ip   = $urandom;
      it.sender_port = 16'($urandom);
    end
    return it;
  endfunction

  task automatic test_classes();
    send_tick();
    send_datagram(32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0);
    send_datagram(32'hFFFF_FFFF, 16'hFFFF, BCAST_ADDR, 1'b0);
    send_datagram(32'h0000_0000, 16'h0000, 32'hE000_0000, 1'b0);
    send_datagram(32'hC0A8_0001, 16'd5000, 32'hEFFF_FFFF, 1'b0);
    send_datagram(32'hC0A8_0001, 16'd5000, 32'hF000_0000, 1'b0);
    send_datagram(32'hC0A8_0001, 16'd5000, 32'hDFFF_FFFF, 1'b0);
    // pong from an unknown peer is consumed without insertion
    send_datagram(32'h0A00_0001, 16'd1234, 32'hFFFF_FFFF, 1'b1);
    send_datagram(32'h0000_0000, 16'h0001, 32'h0A00_0001, 1'b0);
  endtask

  task automatic test_sweep_ageing();
    send_tick();
    send_datagram(32'h0000_0000, 16'h0000, 32'h1234_5678, 1'b1);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    // refill the lowest free slot after removal
    send_datagram(32'h5555_AAAA, 16'hAAAA, 32'hE123_4567, 1'b0);
    send_datagram(32'hAAAA_5555, 16'h5555, 32'h0101_0101, 1'b0);
  endtask

  task automatic test_table_full();
    for (int s = 0; s < TABLE_DEPTH + 2; s++)
      send_datagram(32'h0A00_0100 + s, 16'($urandom), 32'($urandom), 1'b0);
    send_tick();
    send_datagram(32'h0A00_0101, tbl_port[3], BCAST_ADDR, 1'b1);
    send_datagram(32'h5555_AAAA, 16'hAAAA, 32'hE000_0001, 1'b0);
    send_tick();
  endtask

  task automatic test_limit_zero();
    write_limit(8'd0);
    send_tick();
    send_datagram(32'h7F00_0001, 16'd80, 32'h7F00_0001, 1'b0);
    send_datagram(32'h7F00_0002, 16'd81, BCAST_ADDR, 1'b0);
    send_tick();
    send_tick();
  endtask

  task automatic test_backpressure();
    write_limit(8'd3);
    rx_hold_cycles = 300;
    repeat (40) send_item(random_item());
  endtask

  task automatic test_traffic_at_limit(input logic [7:0] limit, input int count);
    write_limit(limit);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    error_count    = 0;
    idle_en        = 1'b1;
    rx_hold_cycles = 0;
    offline_limit  = MAX_MISSED_RST;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      tbl_valid[s]  = 1'b0;
      tbl_ip[s]     = '0;
      tbl_port[s]   = '0;
      tbl_missed[s] = '0;
    end
    pool_ip[0]   = 32'h0000_0000;
    pool_port[0] = 16'h0000;
    pool_ip[1]   = 32'hFFFF_FFFF;
    pool_port[1] = 16'hFFFF;
    for (int p = 2; p < POOL_SIZE; p++) begin
      pool_ip[p]   = $urandom;
      pool_port[p] = 16'($urandom);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_classes();
    test_sweep_ageing();
    test_table_full();
    test_limit_zero();
    test_backpressure();
    test_traffic_at_limit(8'd1, 50);
    test_traffic_at_limit(8'd255, 70);
    test_traffic_at_limit(8'd2, 50);
    test_traffic_at_limit(8'($urandom_range(4, 12)), 40);
    idle_en = 1'b0;
    test_traffic_at_limit(MAX_MISSED_RST, 40);
    wait_drained();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/phlt_pkg.sv
rtl/phlt_cell.sv
rtl/peer_heartbeat_liveness_table_top.sv
rtl/phlt_checker.sv
tb/sv/peer_heartbeat_liveness_table_top_test.sv
